// ----- rtl/sli_pkg.sv -----
// shared types and codes for the sorted list insert/remove block
package sli_pkg;

  // payload field widths
  localparam int KEY_W  = 16;
  localparam int POS_W  = 4;
  localparam int CNT_W  = 5;
  localparam int STAT_W = 2;

  // action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  // memory read address select
  localparam logic [2:0] RD_CNT_M1 = 3'd0;
  localparam logic [2:0] RD_POS    = 3'd1;
  localparam logic [2:0] RD_IDX_P1 = 3'd2;
  localparam logic [2:0] RD_IDX_P2 = 3'd3;
  localparam logic [2:0] RD_IDX_M2 = 3'd4;

  // index register operations
  localparam logic [2:0] IDX_HOLD  = 3'd0;
  localparam logic [2:0] IDX_COUNT = 3'd1;
  localparam logic [2:0] IDX_POS   = 3'd2;
  localparam logic [2:0] IDX_INC   = 3'd3;
  localparam logic [2:0] IDX_DEC   = 3'd4;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] position;
  } item_t;

  typedef struct packed {
    logic [KEY_W-1:0]  removed_key;
    logic [CNT_W-1:0]  entry_count;
    logic [STAT_W-1:0] status;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              rd_en;
    logic [2:0]        rd_sel;
    logic              wr_en;
    logic              wr_key;
    logic [2:0]        idx_op;
    logic              take;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              res_load;
    logic [STAT_W-1:0] res_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_remove;
    logic full;
    logic pos_bad;
    logic cnt_zero;
    logic rd_lt_key;
    logic idx_one;
    logic more_rem;
    logic more_shift;
  } stat_t;

endpackage

// ----- rtl/sli_dpath.sv -----
// datapath: key memory, count, index, item and result registers
module sli_dpath #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  sli_pkg::item_t  in_data,
  input  sli_pkg::cmd_t   cmd,
  output sli_pkg::stat_t  stat,
  output sli_pkg::result_t out_data
);

  localparam int KW   = (KEY_BITS < sli_pkg::KEY_W) ? KEY_BITS : sli_pkg::KEY_W;
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int EW   = CW + 1;
  localparam int CMPW = (CW > sli_pkg::POS_W) ? CW : sli_pkg::POS_W;

  logic [KW-1:0]             mem [DEPTH];
  logic [KW-1:0]             rd_data_r;
  logic                      action_r;
  logic [KW-1:0]             key_r;
  logic [sli_pkg::POS_W-1:0] pos_r;
  logic [CW-1:0]             idx_r;
  logic [CW-1:0]             idx_nxt;
  logic [CW-1:0]             count_r;
  logic [KW-1:0]             taken_r;
  sli_pkg::result_t          out_r;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             wr_addr;
  logic [KW-1:0]             wr_data;

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      sli_pkg::RD_CNT_M1: rd_addr = AW'(count_r - 1'b1);
      sli_pkg::RD_POS:    rd_addr = AW'(pos_r);
      sli_pkg::RD_IDX_P1: rd_addr = AW'(EW'(idx_r) + EW'(1));
      sli_pkg::RD_IDX_P2: rd_addr = AW'(EW'(idx_r) + EW'(2));
      sli_pkg::RD_IDX_M2: rd_addr = AW'(idx_r - CW'(2));
      default:            rd_addr = '0;
    endcase
  end

  assign wr_addr = AW'(idx_r);
  assign wr_data = cmd.wr_key ? key_r : rd_data_r;

  // key memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // item capture and removed key
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_data.action;
      key_r    <= in_data.key[KW-1:0];
      pos_r    <= in_data.position;
      taken_r  <= '0;
    end else if (cmd.take) begin
      taken_r  <= rd_data_r;
    end
  end

  // walking index
  always_comb begin
    case (cmd.idx_op)
      sli_pkg::IDX_HOLD:  idx_nxt = idx_r;
      sli_pkg::IDX_COUNT: idx_nxt = count_r;
      sli_pkg::IDX_POS:   idx_nxt = CW'(pos_r);
      sli_pkg::IDX_INC:   idx_nxt = idx_r + 1'b1;
      sli_pkg::IDX_DEC:   idx_nxt = idx_r - 1'b1;
      default:            idx_nxt = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  // stored entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      count_r <= count_r - 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_r.removed_key <= sli_pkg::KEY_W'(taken_r);
      out_r.entry_count <= sli_pkg::CNT_W'(count_r);
      out_r.status      <= cmd.res_status;
    end
  end

  assign out_data = out_r;

  // status to controller
  assign stat.is_remove  = (action_r == sli_pkg::ACT_REMOVE);
  assign stat.full       = (count_r == CW'(DEPTH));
  assign stat.pos_bad    = (CMPW'(pos_r) >= CMPW'(count_r));
  assign stat.cnt_zero   = (count_r == '0);
  assign stat.rd_lt_key  = (rd_data_r < key_r);
  assign stat.idx_one    = (idx_r == CW'(1));
  assign stat.more_rem   = ((EW'(idx_r) + EW'(1)) < EW'(count_r));
  assign stat.more_shift = ((EW'(idx_r) + EW'(2)) < EW'(count_r));

endmodule

// ----- rtl/sli_ctrl.sv -----
// controller: sequences the search, shift and result for each item
module sli_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  sli_pkg::stat_t stat,
  output sli_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_INS   = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_REM   = 3'd4;
  localparam logic [2:0] S_SHIFT = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                state_r;
  logic [2:0]                state_nxt;
  logic [sli_pkg::STAT_W-1:0] code_r;
  logic [sli_pkg::STAT_W-1:0] code_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        code_nxt = sli_pkg::ST_OK;
        if (!stat.is_remove) begin
          if (stat.full) begin
            code_nxt  = sli_pkg::ST_FULL;
            state_nxt = S_DONE;
          end else if (stat.cnt_zero) begin
            cmd.idx_op = sli_pkg::IDX_COUNT;
            state_nxt  = S_PUT;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = sli_pkg::RD_CNT_M1;
            cmd.idx_op = sli_pkg::IDX_COUNT;
            state_nxt  = S_INS;
          end
        end else if (stat.pos_bad) begin
          code_nxt  = sli_pkg::ST_RANGE;
          state_nxt = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = sli_pkg::RD_POS;
          cmd.idx_op = sli_pkg::IDX_POS;
          state_nxt  = S_REM;
        end
      end
      // walk down from the top, moving larger or equal keys up one slot
      S_INS: begin
        cmd.wr_en = 1'b1;
        if (stat.rd_lt_key) begin
          cmd.wr_key  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.idx_op = sli_pkg::IDX_DEC;
          if (stat.idx_one) begin
            state_nxt = S_PUT;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = sli_pkg::RD_IDX_M2;
          end
        end
      end
      S_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_key  = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_DONE;
      end
      S_REM: begin
        cmd.take = 1'b1;
        if (stat.more_rem) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = sli_pkg::RD_IDX_P1;
          state_nxt  = S_SHIFT;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      // close the gap, moving each later key down one slot
      S_SHIFT: begin
        cmd.wr_en  = 1'b1;
        cmd.idx_op = sli_pkg::IDX_INC;
        if (stat.more_shift) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = sli_pkg::RD_IDX_P2;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = code_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid holds until the item is taken
  assign out_valid_nxt = cmd.res_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      code_r      <= sli_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/sorted_list_insert_remove.sv -----
// sorted list top level: ascending key list with insert and remove by position
// an insert walks down past each stored key not below the new key, moving it up; a remove
// walks up past each entry above the removed position; refused items go straight to the result
// items are taken one at a time, and the walk reads one entry a cycle;
// a result still stalled at the output holds the finished item until it is taken
// reset: synchronous active-low rst_n empties the list and drops any pending result
module sorted_list_insert_remove #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sli_pkg::item_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output sli_pkg::result_t out_data
);

  sli_pkg::cmd_t  cmd;
  sli_pkg::stat_t stat;

  // sequencer
  sli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // memory and registers
  sli_dpath #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ----- rtl/sli_checker.sv -----
// port-level checks for the sorted list block, bound to the top level
module sli_checker #(
  parameter int DEPTH = 16
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input sli_pkg::result_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one item at a time: after an accept the input stalls
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // status is one of the defined codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == sli_pkg::ST_OK) ||
                  (out_data.status == sli_pkg::ST_FULL) ||
                  (out_data.status == sli_pkg::ST_RANGE))
    else $error("undefined status");

  // refused items report no removed key
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != sli_pkg::ST_OK) |-> out_data.removed_key == '0)
    else $error("refused item reports a key");

  // a full refusal reports a full list
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == sli_pkg::ST_FULL) |->
      out_data.entry_count == sli_pkg::CNT_W'(DEPTH))
    else $error("full refusal with wrong count");

endmodule

bind sorted_list_insert_remove sli_checker #(
  .DEPTH (DEPTH)
) u_sli_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
